// ----- rtl/lru_table_replacement_assert.svh -----
// ---------------------------------------------------------------------------
// LRU table assertion macros
// Shared property wrappers clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LRU_TABLE_REPLACEMENT_ASSERT_SVH
`define LRU_TABLE_REPLACEMENT_ASSERT_SVH

// same-cycle implication
`define LRU_CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru table check failed");

// next-cycle implication
`define LRU_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru table check failed");

`endif

// ----- rtl/lru_pkg.sv -----
// ---------------------------------------------------------------------------
// LRU table package
// Shared types and constants for the recency chain and its control.
// ---------------------------------------------------------------------------
`default_nettype none

package lru_pkg;

  localparam int CFG_BITS = 7;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_EVICT  = 1'b1;

  typedef struct packed {
    logic upd;
    logic hit_any;
    logic full_miss;
  } lru_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/lru_cell.sv -----
// ---------------------------------------------------------------------------
// LRU chain cell
// Holds one key and valid bit at a fixed recency position and shifts in
// its neighbor's entry while the update region covers it.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_cell
  import lru_pkg::*;
#(
  parameter int KEY_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lru_ctrl_t           ctrl,
  input  wire logic                cmp_en,
  input  wire logic [KEY_BITS-1:0] cmp_key,
  input  wire logic [KEY_BITS-1:0] prev_key,
  input  wire logic                prev_valid,
  input  wire logic                blk_in,
  output logic [KEY_BITS-1:0]      key_o,
  output logic                     valid_o,
  output logic                     match_o,
  output logic                     blk_o
);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                valid_r, valid_nxt;
  logic                match_r, match_nxt;
  logic                shift;

  always_comb begin
    shift     = ctrl.upd && !blk_in && (!ctrl.full_miss || valid_r);
    blk_o     = blk_in || (ctrl.hit_any ? match_r : !valid_r);
    key_nxt   = shift ? prev_key : key_r;
    valid_nxt = shift ? prev_valid : valid_r;
    match_nxt = cmp_en ? (valid_r && (key_r == cmp_key)) : match_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
    key_r <= key_nxt;
  end

  assign key_o   = key_r;
  assign valid_o = valid_r;
  assign match_o = match_r;

endmodule

`default_nettype wire

// ----- rtl/lru_table_replacement.sv -----
// ---------------------------------------------------------------------------
// Fully associative LRU table
// Input words carry one key access each. Output words report an eviction
// of the least recent key (only on a miss with the table at capacity),
// then always an insert of the accessed key with last_of_run set.
// The user must write the capacity register on the cfg channel only while
// idle; the block itself does not enforce this. Zero acts as one and values
// above ENTRIES act as ENTRIES. For each access, the accept cycle compares
// the key in every cell of the recency chain; the S_UPD state then shifts
// the chain and loads the output stage. A new access, evicting ones included,
// is not accepted until the update of the last one is done.
// The first output word is registered in the output stage by that update.
// A pending insert word is held behind an evict word in a second stage.
// When the receiver stalls, the update waits until the output stage can
// take the new words; no word is dropped. Reset empties the table, clears
// the output stage and sets the capacity to 64. No clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_table_replacement
  import lru_pkg::*;
#(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [KEY_BITS-1:0] in_access_key,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_op_kind,
  output logic [KEY_BITS-1:0]      out_op_key,
  output logic                     out_last_of_run,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_BITS-1:0] cfg_entries_in_use
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CAP_W = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

  typedef enum logic {S_IDLE, S_UPD} state_t;

  state_t               state_r, state_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [CNT_W-1:0]     occ_r, occ_nxt;
  logic [CFG_BITS-1:0]  cfg_r, cfg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [KEY_BITS-1:0]  out_key_r, out_key_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [KEY_BITS-1:0]  pend_key_r, pend_key_nxt;

  lru_ctrl_t            ctrl;
  logic [KEY_BITS-1:0]  cell_key [ENTRIES];
  logic [ENTRIES-1:0]   valid_vec;
  logic [ENTRIES-1:0]   match_vec;
  logic [ENTRIES-1:0]   last_vec;
  logic [ENTRIES:0]     blk_chain;
  logic [KEY_BITS-1:0]  victim_key;
  logic [CAP_W-1:0]     cfg_ext, cap;
  logic                 cmp_en, hit_any, room, out_free, out_take;

  assign in_ready  = (state_r == S_IDLE);
  assign cmp_en    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign blk_chain[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
        lru_cell #(.KEY_BITS(KEY_BITS)) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctrl       (ctrl),
          .cmp_en     (cmp_en),
          .cmp_key    (in_access_key),
          .prev_key   (key_r),
          .prev_valid (1'b1),
          .blk_in     (blk_chain[g]),
          .key_o      (cell_key[g]),
          .valid_o    (valid_vec[g]),
          .match_o    (match_vec[g]),
          .blk_o      (blk_chain[g+1])
        );
      end else begin : g_body
        lru_cell #(.KEY_BITS(KEY_BITS)) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctrl       (ctrl),
          .cmp_en     (cmp_en),
          .cmp_key    (in_access_key),
          .prev_key   (cell_key[g-1]),
          .prev_valid (valid_vec[g-1]),
          .blk_in     (blk_chain[g]),
          .key_o      (cell_key[g]),
          .valid_o    (valid_vec[g]),
          .match_o    (match_vec[g]),
          .blk_o      (blk_chain[g+1])
        );
      end
    end
  endgenerate

  // the least recent valid entry sits just before the first empty cell, or in the last cell when all are valid
  assign last_vec = valid_vec & ~{1'b0, valid_vec[ENTRIES-1:1]};

  always_comb begin
    victim_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      victim_key = victim_key | (last_vec[i] ? cell_key[i] : '0);
    end
  end

  always_comb begin
    cfg_ext = CAP_W'(cfg_r);
    if (cfg_r == '0) begin
      cap = CAP_W'(1);
    end else if (cfg_ext > CAP_W'(ENTRIES)) begin
      cap = CAP_W'(ENTRIES);
    end else begin
      cap = cfg_ext;
    end
    hit_any  = |match_vec;
    room     = CAP_W'(occ_r) < cap;
    out_take = out_valid_r && out_ready;
    out_free = !out_valid_r || (out_ready && !pend_valid_r);

    ctrl.upd       = (state_r == S_UPD) && out_free;
    ctrl.hit_any   = hit_any;
    ctrl.full_miss = !hit_any && !room;
  end

  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    occ_nxt        = occ_r;
    cfg_nxt        = cfg_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_key_nxt    = out_key_r;
    out_last_nxt   = out_last_r;
    pend_valid_nxt = pend_valid_r;
    pend_key_nxt   = pend_key_r;

    if (cfg_valid && cfg_ready) begin
      cfg_nxt = cfg_entries_in_use;
    end

    // advance the output stage
    if (out_take) begin
      if (pend_valid_r) begin
        out_kind_nxt   = OP_INSERT;
        out_key_nxt    = pend_key_r;
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (cmp_en) begin
          key_nxt   = in_access_key;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (ctrl.upd) begin
          out_valid_nxt = 1'b1;
          if (ctrl.full_miss) begin
            out_kind_nxt   = OP_EVICT;
            out_key_nxt    = victim_key;
            out_last_nxt   = 1'b0;
            pend_valid_nxt = 1'b1;
            pend_key_nxt   = key_r;
          end else begin
            out_kind_nxt = OP_INSERT;
            out_key_nxt  = key_r;
            out_last_nxt = 1'b1;
            if (!hit_any) begin
              occ_nxt = occ_r + CNT_W'(1);
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      occ_r        <= '0;
      cfg_r        <= CFG_RESET;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      cfg_r        <= cfg_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
    key_r      <= key_nxt;
    out_kind_r <= out_kind_nxt;
    out_key_r  <= out_key_nxt;
    out_last_r <= out_last_nxt;
    pend_key_r <= pend_key_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_op_kind     = out_kind_r;
  assign out_op_key      = out_key_r;
  assign out_last_of_run = out_last_r;

`include "lru_table_replacement_assert.svh"

  `LRU_CHECK_NOW(a_occ_bound, 1'b1, occ_r <= CNT_W'(ENTRIES))
  `LRU_CHECK_NOW(a_occ_matches_valid, 1'b1, $countones(valid_vec) == int'(occ_r))
  `LRU_CHECK_NOW(a_single_match, 1'b1, $onehot0(match_vec))
  `LRU_CHECK_NOW(a_hit_stops_shift, ctrl.upd && hit_any, blk_chain[ENTRIES])
  `LRU_CHECK_NEXT(a_evict_shown, ctrl.upd && ctrl.full_miss, out_valid && (out_op_kind == OP_EVICT))

endmodule

`default_nettype wire

// ----- sim/lru_table_replacement_tb.sv -----
// ---------------------------------------------------------------------------
// LRU table replacement testbench
// Drives key accesses through the valid/ready input channel and checks
// every output word against a scoreboard that tracks the table contents
// and recency ranks. The capacity register is rewritten between phases,
// including its extremes. Both sides idle at random, and once the
// receiver holds off long enough to back the block up into its input.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_table_replacement_tb
  import lru_pkg::*;
();

  localparam int ENTRIES      = 64;
  localparam int KEY_BITS     = 32;
  localparam int POOL         = 72;
  localparam int PHASE_ITEMS  = 95;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int LIMIT        = 400000;

  typedef struct packed {
    logic                kind;
    logic [KEY_BITS-1:0] key;
    logic                last;
  } table_word_t;

  class lru_scoreboard;
    logic [KEY_BITS-1:0] key_store [ENTRIES];
    logic                entry_valid [ENTRIES];
    logic [5:0]          recency_rank [ENTRIES];
    logic [6:0]          occupied;
    logic [CFG_BITS-1:0] capacity;
    table_word_t         expected_words [$];
    int                  errors, n_hit, n_miss, n_evict, n_access;

    function new();
      foreach (entry_valid[i]) begin
        entry_valid[i]  = 1'b0;
        recency_rank[i] = '0;
        key_store[i]    = '0;
      end
      occupied = '0;
      capacity = CFG_RESET;
    endfunction

    function void set_capacity(logic [CFG_BITS-1:0] value);
      capacity = value;
    endfunction

    function void queue_word(table_word_t w);
      expected_words = {expected_words, w};
    endfunction

    function void age_below(int limit);
      foreach (entry_valid[i])
        if (entry_valid[i] && recency_rank[i] < limit) recency_rank[i]++;
    endfunction

    function void note_access(logic [KEY_BITS-1:0] key);
      int          hit_cell, free_cell, victim, cap;
      logic [5:0]  worst;
      table_word_t w;
      hit_cell  = -1;
      free_cell = -1;
      victim    = -1;
      worst     = '0;
      cap = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
      n_access++;
      foreach (entry_valid[i])
        if (hit_cell < 0 && entry_valid[i] && key_store[i] == key) hit_cell = i;
      if (hit_cell >= 0) begin
        n_hit++;
        age_below(recency_rank[hit_cell]);
        recency_rank[hit_cell] = '0;
      end else begin
        n_miss++;
        foreach (entry_valid[i])
          if (free_cell < 0 && !entry_valid[i]) free_cell = i;
        if (occupied < cap && free_cell >= 0) begin
          age_below(ENTRIES);
          entry_valid[free_cell]  = 1'b1;
          key_store[free_cell]    = key;
          recency_rank[free_cell] = '0;
          occupied++;
        end else begin
          foreach (entry_valid[i])
            if (entry_valid[i] && (victim < 0 || recency_rank[i] > worst)) begin
              victim = i;
              worst  = recency_rank[i];
            end
          w.kind = OP_EVICT;
          w.key  = key_store[victim];
          w.last = 1'b0;
          queue_word(w);
          age_below(worst);
          key_store[victim]    = key;
          recency_rank[victim] = '0;
        end
      end
      w.kind = OP_INSERT;
      w.key  = key;
      w.last = 1'b1;
      queue_word(w);
    endfunction

    function void check_word(logic kind, logic [KEY_BITS-1:0] key, logic last);
      table_word_t w;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word kind=%0b key=%h last=%0b", $time, kind, key, last);
        return;
      end
      w = expected_words.pop_front();
      if (kind !== w.kind) begin
        errors++;
        $display("%0t: op_kind expected %0b actual %0b", $time, w.kind, kind);
      end
      if (key !== w.key) begin
        errors++;
        $display("%0t: op_key expected %h actual %h", $time, w.key, key);
      end
      if (last !== w.last) begin
        errors++;
        $display("%0t: last_of_run expected %0b actual %0b", $time, w.last, last);
      end
      if (w.kind == OP_EVICT) n_evict++;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [KEY_BITS-1:0] in_access_key;
  logic                out_valid;
  logic                out_ready;
  logic                out_op_kind;
  logic [KEY_BITS-1:0] out_op_key;
  logic                out_last_of_run;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_entries_in_use;

  lru_scoreboard sb = new();
  bit            tx_calm, rx_calm, hold_req;
  int            stall_left, hold_left, cycle_count, settings_written;

  lru_table_replacement #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_access_key      (in_access_key),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_op_kind        (out_op_kind),
    .out_op_key         (out_op_key),
    .out_last_of_run    (out_last_of_run),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_entries_in_use (cfg_entries_in_use)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, sb.expected_words.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_access(in_access_key);
      if (cfg_valid && cfg_ready) sb.set_capacity(cfg_entries_in_use);
      if (out_valid && out_ready) begin
        sb.check_word(out_op_kind, out_op_key, out_last_of_run);
        stall_left = rx_calm ? 0 : $urandom_range(0, 15);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_access(input logic [KEY_BITS-1:0] key);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_access_key <= key;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_capacity(input logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_valid          <= 1'b1;
    cfg_entries_in_use <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  initial begin
    logic [KEY_BITS-1:0] pool [POOL];
    logic [CFG_BITS-1:0] cap_plan [10];
    int                  eff, span;

    in_valid           = 1'b0;
    in_access_key      = '0;
    cfg_valid          = 1'b0;
    cfg_entries_in_use = CFG_RESET;
    out_ready          = 1'b0;
    rst_n              = 1'b0;
    hold_req           = 1'b0;
    stall_left         = 0;
    hold_left          = 0;
    cycle_count        = 0;
    settings_written   = 0;
    foreach (pool[i]) pool[i] = $urandom();
    pool[0] = '0;
    pool[1] = '1;
    cap_plan = '{7'd64, 7'd1, 7'd9, 7'd127, 7'd3, 7'd65, 7'd0, 7'd20, 7'd64, 7'd2};

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'h0000_0000);
    send_access(32'h1234_5678);
    send_access(32'hFFFF_FFFF);
    send_access(32'h8000_0000);
    send_access(32'h0000_0001);
    settle();
    program_capacity(7'd2);
    send_access(32'h0000_0000);
    send_access(32'hDEAD_BEEF);
    send_access(32'hCAFE_F00D);
    send_access(32'hDEAD_BEEF);
    settle();
    program_capacity(7'd0);
    send_access(32'h5555_5555);
    send_access(32'hAAAA_AAAA);
    send_access(32'hAAAA_AAAA);
    settle();
    program_capacity(7'd127);
    send_access(32'h0F0F_0F0F);
    send_access(32'hF0F0_F0F0);
    send_access(32'h5555_5555);
    settle();
    program_capacity(7'd1);
    send_access(32'h0000_0001);
    send_access(32'h0000_0002);
    settle();

    foreach (cap_plan[p]) begin
      program_capacity(cap_plan[p]);
      eff  = (cap_plan[p] == 0) ? 1 : (cap_plan[p] > ENTRIES) ? ENTRIES : cap_plan[p];
      span = eff + $urandom_range(1, 6);
      if (span > POOL) span = POOL;
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (p == 8) begin
        tx_calm = 1'b1;
        @(posedge clk);
        hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) send_access($urandom());
        else send_access(pool[$urandom_range(0, span - 1)]);
      end
      settle();
    end

    $display("Ran %0d accesses (%0d hits, %0d misses, %0d evictions) over %0d capacity writes,",
             sb.n_access, sb.n_hit, sb.n_miss, sb.n_evict, settings_written);
    $display("with random idling on both sides and one long receiver hold-off.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
